// ----- hdl/mmb_pkg.sv -----
package mmb_pkg;

    localparam int RAM_WORDS     = 524288;
    localparam int SCRATCH_WORDS = 1024;
    localparam int EXP_WORDS     = 32768;
    localparam int ROM_WORDS     = 131072;
    localparam int SINK_WORDS    = 16384;

    localparam int RAM_AW     = $clog2(RAM_WORDS);
    localparam int SCRATCH_AW = $clog2(SCRATCH_WORDS);
    localparam int EXP_AW     = $clog2(EXP_WORDS);
    localparam int ROM_AW     = $clog2(ROM_WORDS);
    localparam int SINK_AW    = $clog2(SINK_WORDS);

    localparam int MAX_CLR_A = (RAM_WORDS > EXP_WORDS) ? RAM_WORDS : EXP_WORDS;
    localparam int MAX_CLR_B = (SCRATCH_WORDS > SINK_WORDS) ? SCRATCH_WORDS : SINK_WORDS;
    localparam int CLR_WORDS = (MAX_CLR_A > MAX_CLR_B) ? MAX_CLR_A : MAX_CLR_B;
    localparam int CLR_AW    = $clog2(CLR_WORDS);

    localparam int MAX_WORDS = (CLR_WORDS > ROM_WORDS) ? CLR_WORDS : ROM_WORDS;
    localparam int IDX_W     = $clog2(MAX_WORDS);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] WINDOW_MASK   = 32'h1FC0_0000;
    localparam logic [31:0] WINDOW_BASE   = 32'h1F80_0000;
    localparam logic [15:0] SCRATCH_LIMIT = 16'h1000;
    localparam logic [15:0] RAM_SEG_K0    = 16'h0000;
    localparam logic [15:0] RAM_SEG_K1    = 16'h8000;
    localparam logic [15:0] RAM_SEG_K2    = 16'hA000;
    localparam logic [15:0] RAM_SEG_ALT   = 16'h3C00;
    localparam logic [15:0] EXP_PAGE      = 16'h1F00;
    localparam logic [15:0] ROM_SEG_K0    = 16'h1FC0;
    localparam logic [15:0] ROM_SEG_K1    = 16'h9FC0;
    localparam logic [15:0] ROM_SEG_K2    = 16'hBFC0;

    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_ROM_LOAD = 2'd2;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    typedef enum logic [2:0] {
        REG_RAM     = 3'd0,
        REG_SCRATCH = 3'd1,
        REG_EXP     = 3'd2,
        REG_ROM     = 3'd3,
        REG_SINK    = 3'd4,
        REG_HW      = 3'd5
    } t_region;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_RAM,
        SEL_SCRATCH,
        SEL_EXP,
        SEL_ROM,
        SEL_SINK
    } t_sel;

    typedef enum logic [1:0] {
        RM_NONE,
        RM_HALF,
        RM_WORD
    } t_rmode;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
        logic        cache_isolate;
    } t_request;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  target_region;
        logic        write_dropped;
    } t_result;

    typedef struct packed {
        t_sel             sel;
        logic             wr;
        t_rmode           rmode;
        logic             half_hi;
        logic [3:0]       be;
        logic [31:0]      wdata;
        logic [IDX_W-1:0] idx;
        t_region          region;
        logic             dropped;
    } t_cmd;

endpackage

// ----- hdl/mmb_front.sv -----
module mmb_front (
    input  mmb_pkg::t_request i_request,
    output mmb_pkg::t_cmd     o_cmd
);
    import mmb_pkg::*;

    logic [15:0] pg;
    logic [13:0] wo;
    logic        in_window;
    logic        is_ram;
    logic        is_exp;
    logic        is_rom;
    logic [31:0] raw_ram;
    logic [31:0] raw_scr;
    logic [31:0] raw_exp;
    logic [31:0] raw_rom;
    logic [31:0] raw_rom_ld;
    logic [31:0] raw_sink;
    logic        is_word;
    logic        is_write;
    t_cmd        cmd;

    always_comb begin
        pg = i_request.address[31:16];
        wo = i_request.address[15:2];
        in_window = (i_request.address & WINDOW_MASK) == WINDOW_BASE;
        is_ram = (pg[15:7] == RAM_SEG_K0[15:7]) || (pg[15:7] == RAM_SEG_K1[15:7]) ||
                 (pg[15:7] == RAM_SEG_K2[15:7]) || (pg[15:7] == RAM_SEG_ALT[15:7]);
        is_exp = pg[15:1] == EXP_PAGE[15:1];
        is_rom = (pg[15:3] == ROM_SEG_K0[15:3]) || (pg[15:3] == ROM_SEG_K1[15:3]) ||
                 (pg[15:3] == ROM_SEG_K2[15:3]);
        raw_ram    = {13'd0, pg[4:0], wo};
        raw_scr    = {22'd0, i_request.address[11:2]};
        raw_exp    = {17'd0, pg[0], wo};
        raw_rom    = {15'd0, pg[2:0], wo};
        raw_rom_ld = {2'd0, i_request.address[31:2]};
        raw_sink   = {18'd0, wo};
        is_word    = i_request.access_size[1];
        is_write   = i_request.operation == OP_WRITE;

        cmd         = '0;
        cmd.sel     = SEL_NONE;
        cmd.rmode   = RM_NONE;
        cmd.region  = REG_RAM;
        cmd.half_hi = i_request.address[1];
        cmd.wdata   = i_request.write_data;
        cmd.be      = 4'hF;
        if (!is_word) begin
            if (i_request.access_size == SZ_HALF) begin
                cmd.be    = i_request.address[1] ? 4'b1100 : 4'b0011;
                cmd.wdata = i_request.write_data << (5'd16 * {4'd0, i_request.address[1]});
            end else begin
                cmd.be    = 4'b0001 << i_request.address[1:0];
                cmd.wdata = i_request.write_data << (5'd8 * {3'd0, i_request.address[1:0]});
            end
        end

        if (i_request.operation == OP_ROM_LOAD) begin
            cmd.sel    = SEL_ROM;
            cmd.wr     = 1'b1;
            cmd.be     = 4'hF;
            cmd.wdata  = i_request.write_data;
            cmd.idx    = IDX_W'(raw_rom_ld[ROM_AW-1:0]);
            cmd.region = REG_ROM;
        end else if (i_request.operation == OP_READ || is_write) begin
            if (in_window) begin
                if (i_request.address[15:0] < SCRATCH_LIMIT) begin
                    cmd.region = REG_SCRATCH;
                    cmd.sel    = SEL_SCRATCH;
                    cmd.idx    = IDX_W'(raw_scr[SCRATCH_AW-1:0]);
                end else begin
                    cmd.region = REG_HW;
                end
            end else if (is_ram) begin
                cmd.region = REG_RAM;
                cmd.sel    = SEL_RAM;
                cmd.idx    = IDX_W'(raw_ram[RAM_AW-1:0]);
            end else if (is_exp) begin
                cmd.region = REG_EXP;
                cmd.sel    = SEL_EXP;
                cmd.idx    = IDX_W'(raw_exp[EXP_AW-1:0]);
            end else if (is_rom && !is_write) begin
                cmd.region = REG_ROM;
                cmd.sel    = SEL_ROM;
                cmd.idx    = IDX_W'(raw_rom[ROM_AW-1:0]);
            end else begin
                cmd.region = is_rom ? REG_ROM : REG_SINK;
                cmd.sel    = SEL_SINK;
                cmd.idx    = IDX_W'(raw_sink[SINK_AW-1:0]);
            end

            if (is_write) begin
                cmd.wr = cmd.sel != SEL_NONE;
                if (i_request.cache_isolate && !in_window) begin
                    cmd.dropped = 1'b1;
                    cmd.wr      = 1'b0;
                    cmd.sel     = SEL_NONE;
                end
            end else if (cmd.sel != SEL_NONE && i_request.access_size != SZ_BYTE) begin
                cmd.rmode = is_word ? RM_WORD : RM_HALF;
            end else begin
                cmd.sel = SEL_NONE;
            end
        end
        o_cmd = cmd;
    end

endmodule

// ----- hdl/mmb_queue.sv -----
module mmb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mmb_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output mmb_pkg::t_cmd o_cmd
);
    import mmb_pkg::*;

    t_cmd            r_entry [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_cmd;
        end
    end

    assign o_full  = r_count == Q_CW'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_entry[r_rp];

endmodule

// ----- hdl/mmb_back.sv -----
module mmb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  mmb_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_clearing,
    output logic             o_strobe,
    output mmb_pkg::t_result o_result
);
    import mmb_pkg::*;

    logic [31:0] ram_mem  [RAM_WORDS];
    logic [31:0] scr_mem  [SCRATCH_WORDS];
    logic [31:0] exp_mem  [EXP_WORDS];
    logic [31:0] rom_mem  [ROM_WORDS];
    logic [31:0] sink_mem [SINK_WORDS];

    logic              r_clearing;
    logic [CLR_AW-1:0] r_clr_idx;
    logic              r_a_valid;
    t_sel              r_a_sel;
    t_rmode            r_a_rmode;
    logic              r_a_half_hi;
    t_region           r_a_region;
    logic              r_a_dropped;
    logic [31:0]       r_ram_q;
    logic [31:0]       r_scr_q;
    logic [31:0]       r_exp_q;
    logic [31:0]       r_rom_q;
    logic [31:0]       r_sink_q;
    logic              r_strobe;
    t_result           r_result;

    logic              go;
    logic [3:0]        be;
    logic              we_ram;
    logic              we_scr;
    logic              we_exp;
    logic              we_rom;
    logic              we_sink;
    logic [31:0]       d_ram;
    logic [31:0]       d_scr;
    logic [31:0]       d_exp;
    logic [31:0]       d_sink;
    logic [RAM_AW-1:0]     a_ram;
    logic [SCRATCH_AW-1:0] a_scr;
    logic [EXP_AW-1:0]     a_exp;
    logic [ROM_AW-1:0]     a_rom;
    logic [SINK_AW-1:0]    a_sink;
    logic [31:0]       word_q;
    logic [15:0]       half_q;
    t_result           n_result;

    always_comb begin
        go      = i_cmd_valid && !r_clearing;
        be      = r_clearing ? 4'hF : i_cmd.be;
        we_ram  = r_clearing || (go && i_cmd.wr && i_cmd.sel == SEL_RAM);
        we_scr  = r_clearing || (go && i_cmd.wr && i_cmd.sel == SEL_SCRATCH);
        we_exp  = r_clearing || (go && i_cmd.wr && i_cmd.sel == SEL_EXP);
        we_sink = r_clearing || (go && i_cmd.wr && i_cmd.sel == SEL_SINK);
        we_rom  = go && i_cmd.wr && i_cmd.sel == SEL_ROM;
        d_ram   = r_clearing ? 32'h0000_0000 : i_cmd.wdata;
        d_scr   = r_clearing ? 32'h0000_0000 : i_cmd.wdata;
        d_exp   = r_clearing ? 32'hFFFF_FFFF : i_cmd.wdata;
        d_sink  = r_clearing ? 32'h0000_0000 : i_cmd.wdata;
        a_ram   = r_clearing ? r_clr_idx[RAM_AW-1:0] : i_cmd.idx[RAM_AW-1:0];
        a_scr   = r_clearing ? r_clr_idx[SCRATCH_AW-1:0] : i_cmd.idx[SCRATCH_AW-1:0];
        a_exp   = r_clearing ? r_clr_idx[EXP_AW-1:0] : i_cmd.idx[EXP_AW-1:0];
        a_sink  = r_clearing ? r_clr_idx[SINK_AW-1:0] : i_cmd.idx[SINK_AW-1:0];
        a_rom   = i_cmd.idx[ROM_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (we_ram && be[b]) begin
                ram_mem[a_ram][8*b +: 8] <= d_ram[8*b +: 8];
            end
        end
        r_ram_q <= ram_mem[a_ram];
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (we_scr && be[b]) begin
                scr_mem[a_scr][8*b +: 8] <= d_scr[8*b +: 8];
            end
        end
        r_scr_q <= scr_mem[a_scr];
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (we_exp && be[b]) begin
                exp_mem[a_exp][8*b +: 8] <= d_exp[8*b +: 8];
            end
        end
        r_exp_q <= exp_mem[a_exp];
    end

    always_ff @(posedge i_clk) begin
        if (we_rom) begin
            rom_mem[a_rom] <= i_cmd.wdata;
        end
        r_rom_q <= rom_mem[a_rom];
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (we_sink && be[b]) begin
                sink_mem[a_sink][8*b +: 8] <= d_sink[8*b +: 8];
            end
        end
        r_sink_q <= sink_mem[a_sink];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_a_valid  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == CLR_AW'(CLR_WORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_a_valid <= go;
            r_strobe  <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sel     <= i_cmd.sel;
        r_a_rmode   <= i_cmd.rmode;
        r_a_half_hi <= i_cmd.half_hi;
        r_a_region  <= i_cmd.region;
        r_a_dropped <= i_cmd.dropped;
        r_result    <= n_result;
    end

    always_comb begin
        case (r_a_sel)
            SEL_RAM:     word_q = r_ram_q;
            SEL_SCRATCH: word_q = r_scr_q;
            SEL_EXP:     word_q = r_exp_q;
            SEL_ROM:     word_q = r_rom_q;
            SEL_SINK:    word_q = r_sink_q;
            default:     word_q = 32'h0000_0000;
        endcase
        half_q = r_a_half_hi ? word_q[31:16] : word_q[15:0];
        n_result               = '0;
        n_result.target_region = r_a_region;
        n_result.write_dropped = r_a_dropped;
        case (r_a_rmode)
            RM_WORD: n_result.read_data = word_q;
            RM_HALF: n_result.read_data = {{16{half_q[15]}}, half_q};
            default: n_result.read_data = 32'h0000_0000;
        endcase
    end

    assign o_pop      = go;
    assign o_clearing = r_clearing;
    assign o_strobe   = r_strobe;
    assign o_result   = r_result;

endmodule

// ----- hdl/mirrored_memory_map_bus.sv -----
// Path: a transaction accepted while busy is low passes through the queue entry, the
// back end's stage register and the result register before the result strobe rises.
// Throughput: one transaction per cycle; the receiver cannot stall, so busy stays low after the clearing pass.
// Reset: synchronous, active low; afterwards a clearing pass runs over the stores,
// one word of each per cycle, through CLR_WORDS (524288) indices with busy held high.
// The boot ROM is not cleared and holds undefined data until loaded.
module mirrored_memory_map_bus (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mmb_pkg::t_request i_request,
    output logic              o_busy,
    output logic              o_strobe,
    output mmb_pkg::t_result  o_result
);
    import mmb_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic pop;
    logic clearing;
    logic push;

    assign o_busy = queue_full || clearing;
    assign push   = i_start && !o_busy;

    mmb_front u_front (
        .i_request (i_request),
        .o_cmd     (front_cmd)
    );

    mmb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    mmb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

// ----- hdl/mmb_checker.sv -----
module mmb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_strobe,
    input mmb_pkg::t_result  o_result
);
    import mmb_pkg::*;

    a_busy_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("Busy is low right after reset.");

    a_quiet_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("Result strobe right after reset.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_strobe)
        else $error("Accepted transaction produced no result.");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start && !o_busy && i_rst_n, 3))
        else $error("Result without an accepted transaction.");

    a_dropped_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.write_dropped) |-> (o_result.read_data == 32'd0))
        else $error("Dropped write returned read data.");

endmodule

bind mirrored_memory_map_bus mmb_checker u_mmb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .o_busy    (o_busy),
    .o_strobe  (o_strobe),
    .o_result  (o_result)
);
